>>> sv/vns_pkg.sv
`default_nettype none

package vns_pkg;

   // default vertex store depth
   localparam int MAX_VERTICES_DEFAULT = 1024;

   // field widths
   localparam int IDX_W      = 10;
   localparam int SLOT_W     = 17;
   localparam int ADDR_MAX_W = 16;
   localparam int POS_W      = 24;
   localparam int NRM_W      = 16;
   localparam int FRAC_W     = 14;

   // normalizer widths
   localparam int MAG_W = 30;
   localparam int LEN_W = 31;
   localparam int RAD_W = 62;
   localparam int Q_W   = 15;
   localparam int NUM_W = 45;

   // 1.0 in q1.14
   localparam logic [Q_W-1:0] ONE_Q14 = 15'd16384;

   // action codes carried in tuser
   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_TRI  = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   // classified work handed from front to back
   typedef enum logic [1:0] {
      JOB_LOAD,
      JOB_TRI,
      JOB_READ,
      JOB_ZERO_READ
   } job_kind_type;

   typedef struct packed {
      job_kind_type             kind;
      logic [ADDR_MAX_W-1:0]    a;
      logic [ADDR_MAX_W-1:0]    b;
      logic [ADDR_MAX_W-1:0]    c;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [POS_W-1:0]  pz;
   } job_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef struct packed {
      logic                    nonzero;
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] z;
   } normal_type;

   typedef enum logic [4:0] {
      B_CLEAR,
      B_IDLE,
      B_LD_A,
      B_LD_B,
      B_LD_C,
      B_LD_D,
      B_MUL,
      B_MAG,
      B_NORM,
      B_RD_ACC,
      B_RD_MAG,
      B_START,
      B_WAIT,
      B_RMW_RD,
      B_RMW_WR,
      B_OUT
   } back_state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_SQ,
      U_ROOT,
      U_DSET,
      U_DIV,
      U_DONE
   } unit_state_type;

endpackage

`default_nettype wire

>>> sv/vns_front.sv
`default_nettype none

module vns_front import vns_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire action_type              action,
   input  wire logic [IDX_W-1:0]        vertex_index,
   input  wire logic signed [POS_W-1:0] pos_x,
   input  wire logic signed [POS_W-1:0] pos_y,
   input  wire logic signed [POS_W-1:0] pos_z,
   input  wire logic [IDX_W-1:0]        corner_a,
   input  wire logic [IDX_W-1:0]        corner_b,
   input  wire logic [IDX_W-1:0]        corner_c,
   input  wire back_status_type         status,
   output logic                         job_valid,
   output job_type                      job
);

   localparam logic [SLOT_W-1:0] LIMIT = SLOT_W'(MAX_VERTICES);

   job_type    q_ff [2];
   job_type    q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, wr_en;
   logic       v_ok, a_ok, b_ok, c_ok;

   // range checks
   assign v_ok = SLOT_W'(vertex_index) < LIMIT;
   assign a_ok = SLOT_W'(corner_a) < LIMIT;
   assign b_ok = SLOT_W'(corner_b) < LIMIT;
   assign c_ok = SLOT_W'(corner_c) < LIMIT;

   // classify the incoming item
   always_comb begin
      q_in      = '0;
      q_in.kind = JOB_READ;
      q_in.a    = ADDR_MAX_W'(vertex_index);
      q_in.px   = pos_x;
      q_in.py   = pos_y;
      q_in.pz   = pos_z;
      push      = 1'b0;
      unique case (action)
         ACT_LOAD: begin
            q_in.kind = JOB_LOAD;
            push      = v_ok;
         end
         ACT_TRI: begin
            q_in.kind = JOB_TRI;
            q_in.a    = ADDR_MAX_W'(corner_a);
            q_in.b    = ADDR_MAX_W'(corner_b);
            q_in.c    = ADDR_MAX_W'(corner_c);
            push      = a_ok && b_ok && c_ok;
         end
         ACT_READ: begin
            q_in.kind = v_ok ? JOB_READ : JOB_ZERO_READ;
            push      = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // two-entry job queue
   assign in_ready  = (count_ff != 2'd2) && !status.clearing;
   assign wr_en     = in_valid && in_ready && push;
   assign job_valid = (count_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ status.pop;
      count_in  = count_ff + 2'(wr_en) - 2'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/vns_unit.sv
`default_nettype none

module vns_unit import vns_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [2:0][MAG_W-1:0]  mag,
   input  wire logic [2:0]             neg,
   output logic                        done,
   output normal_type                  result
);

   unit_state_type            state_ff, state_in;
   logic [2:0][MAG_W-1:0]     mag_ff, mag_in;
   logic [2:0]                neg_ff, neg_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [1:0]                k_ff, k_in;
   logic [2*MAG_W-1:0]        prod_ff, prod_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [LEN_W+2:0]          rem_ff, rem_in;
   logic [LEN_W-1:0]          root_ff, root_in;
   logic [Q_W-1:0]            num_ff, num_in;
   logic [Q_W-1:0]            q_ff, q_in;
   normal_type                res_ff, res_in;

   logic [LEN_W+2:0]          rem_next, trial;
   logic [NUM_W-1:0]          numer;
   logic [LEN_W:0]            part;
   logic                      qbit;
   logic [Q_W-1:0]            q_next, q_clip;
   logic signed [NRM_W-1:0]   comp;

   assign done   = (state_ff == U_DONE);
   assign result = res_ff;

   // squares, digit-by-digit root, then three restoring divisions
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      prod_in  = prod_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      rem_next = {rem_ff[LEN_W:0], rad_ff[RAD_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      numer    = NUM_W'({mag_ff[k_ff], {FRAC_W{1'b0}}}) + NUM_W'(root_ff >> 1);
      part     = {rem_ff[LEN_W-1:0], num_ff[Q_W-1]};
      qbit     = part >= {1'b0, root_ff};
      q_next   = {q_ff[Q_W-2:0], qbit};
      q_clip   = (q_next > ONE_Q14) ? ONE_Q14 : q_next;
      comp     = neg_ff[k_ff] ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               mag_in   = mag;
               neg_in   = neg;
               cnt_in   = 5'd0;
               rad_in   = '0;
               state_in = U_SQ;
            end
         end
         U_SQ: begin
            if (cnt_ff != 5'd3) begin
               prod_in = mag_ff[cnt_ff[1:0]] * mag_ff[cnt_ff[1:0]];
            end
            if (cnt_ff != 5'd0) begin
               rad_in = rad_ff + RAD_W'(prod_ff);
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in   = 5'd0;
               rem_in   = '0;
               root_in  = '0;
               state_in = U_ROOT;
            end
         end
         U_ROOT: begin
            rad_in = rad_ff << 2;
            if (rem_next >= trial) begin
               rem_in  = rem_next - trial;
               root_in = {root_ff[LEN_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_next;
               root_in = {root_ff[LEN_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(LEN_W-1)) begin
               k_in = 2'd0;
               if (root_in == '0) begin
                  res_in   = '0;
                  state_in = U_DONE;
               end else begin
                  state_in = U_DSET;
               end
            end
         end
         U_DSET: begin
            rem_in   = (LEN_W+3)'(numer[NUM_W-1:Q_W]);
            num_in   = numer[Q_W-1:0];
            q_in     = '0;
            cnt_in   = 5'd0;
            state_in = U_DIV;
         end
         U_DIV: begin
            rem_in = qbit ? (LEN_W+3)'(part - {1'b0, root_ff}) : (LEN_W+3)'(part);
            q_in   = q_next;
            num_in = num_ff << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(Q_W-1)) begin
               case (k_ff)
                  2'd0:    res_in.x = comp;
                  2'd1:    res_in.y = comp;
                  default: res_in.z = comp;
               endcase
               if (k_ff == 2'd2) begin
                  res_in.nonzero = 1'b1;
                  state_in       = U_DONE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = U_DSET;
               end
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end

`ifndef SYNTHESIS
   // a result without the nonzero flag has only zero components
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DONE && !res_ff.nonzero) |->
      (res_ff.x == 0 && res_ff.y == 0 && res_ff.z == 0))
      else $error("zero-length result carries nonzero components");

   // divisions only start with a nonzero length
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DSET) |-> (root_ff != '0))
      else $error("division started with zero length");
`endif

endmodule

`default_nettype wire

>>> sv/vns_back.sv
`default_nettype none

module vns_back import vns_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire job_type                job,
   output back_status_type             status,
   output logic                        unit_start,
   output logic [2:0][MAG_W-1:0]       unit_mag,
   output logic [2:0]                  unit_neg,
   input  wire logic                   unit_done,
   input  wire normal_type             unit_result,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output normal_type                  out_data
);

   localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int EDGE_W = POS_W + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int CR_W   = PROD_W + 1;
   localparam int CMAG_W = CR_W - 1;
   localparam int VEC_W  = 3 * POS_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_VERTICES - 1);

   // position and accumulator stores
   logic [VEC_W-1:0] pos_mem [MAX_VERTICES];
   logic [VEC_W-1:0] acc_mem [MAX_VERTICES];
   logic [VEC_W-1:0] pos_rd_ff, acc_rd_ff;
   logic [AW-1:0]    pos_addr, acc_addr;
   logic             pos_we, acc_we;
   logic [VEC_W-1:0] pos_wdata, acc_wdata;

   back_state_type          state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   job_type                 job_ff, job_in;
   logic signed [POS_W-1:0] pa_ff [3];
   logic signed [POS_W-1:0] pa_in [3];
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e1_in [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] e2_in [3];
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [CR_W-1:0]   cr_ff [3];
   logic signed [CR_W-1:0]   cr_in [3];
   logic [2:0]               cnt_ff, cnt_in;
   logic [CMAG_W-1:0]        mag_ff [3];
   logic [CMAG_W-1:0]        mag_in [3];
   logic [2:0]               neg_ff, neg_in;
   logic [1:0]               corner_ff, corner_in;
   normal_type               nvec_ff, nvec_in;
   logic                     out_valid_ff, out_valid_in;
   normal_type               out_ff, out_in;

   logic signed [POS_W-1:0]  rd_pos [3];
   logic signed [POS_W-1:0]  rd_acc [3];
   logic signed [POS_W:0]    acc_wide [3];
   logic signed [EDGE_W-1:0] mul_a, mul_b;
   logic [2:0]               mul_k;
   logic [1:0]               cr_idx;
   logic [AW-1:0]            corner_addr;
   logic                     mag_big, mag_zero;

   function automatic logic signed [POS_W-1:0] sat_add(
      input logic signed [POS_W-1:0] acc,
      input logic signed [NRM_W-1:0] d
   );
      logic signed [POS_W:0] s;
      s = (POS_W+1)'(acc) + (POS_W+1)'(d);
      if (s[POS_W] != s[POS_W-1]) begin
         return s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end
      return s[POS_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_addr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_addr] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_addr];
   end

   // unpack read data
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rd_pos[i]   = pos_rd_ff[i*POS_W +: POS_W];
         rd_acc[i]   = acc_rd_ff[i*POS_W +: POS_W];
         acc_wide[i] = (POS_W+1)'(rd_acc[i]);
      end
   end

   // cross product operand schedule
   always_comb begin
      case (cnt_ff)
         3'd0:    begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1:    begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2:    begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3:    begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4:    begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         3'd5:    begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
         default: begin mul_a = e1_ff[0]; mul_b = e2_ff[0]; end
      endcase
   end

   assign mul_k  = cnt_ff - 3'd1;
   assign cr_idx = mul_k[2:1];

   always_comb begin
      case (corner_ff)
         2'd0:    corner_addr = job_ff.a[AW-1:0];
         2'd1:    corner_addr = job_ff.b[AW-1:0];
         default: corner_addr = job_ff.c[AW-1:0];
      endcase
   end

   always_comb begin
      mag_big  = 1'b0;
      mag_zero = 1'b1;
      for (int i = 0; i < 3; i++) begin
         mag_big  = mag_big || (mag_ff[i][CMAG_W-1:MAG_W] != '0);
         mag_zero = mag_zero && (mag_ff[i] == '0);
      end
   end

   assign unit_neg = neg_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit_mag[i] = mag_ff[i][MAG_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      clr_in          = clr_ff;
      job_in          = job_ff;
      pa_in           = pa_ff;
      e1_in           = e1_ff;
      e2_in           = e2_ff;
      prod_in         = prod_ff;
      cr_in           = cr_ff;
      cnt_in          = cnt_ff;
      mag_in          = mag_ff;
      neg_in          = neg_ff;
      corner_in       = corner_ff;
      nvec_in         = nvec_ff;
      out_valid_in    = out_valid_ff && !out_ready;
      out_in          = out_ff;
      pos_we          = 1'b0;
      acc_we          = 1'b0;
      pos_addr        = job_ff.a[AW-1:0];
      acc_addr        = job_ff.a[AW-1:0];
      pos_wdata       = {job.pz, job.py, job.px};
      acc_wdata       = '0;
      unit_start      = 1'b0;
      status.pop      = 1'b0;
      status.clearing = (state_ff == B_CLEAR);
      unique case (state_ff)
         B_CLEAR: begin
            acc_we   = 1'b1;
            acc_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (job_valid) begin
               status.pop = 1'b1;
               job_in     = job;
               unique case (job.kind)
                  JOB_LOAD: begin
                     pos_we   = 1'b1;
                     acc_we   = 1'b1;
                     pos_addr = job.a[AW-1:0];
                     acc_addr = job.a[AW-1:0];
                  end
                  JOB_TRI:  state_in = B_LD_A;
                  JOB_READ: state_in = B_RD_ACC;
                  default: begin
                     nvec_in  = '0;
                     state_in = B_OUT;
                  end
               endcase
            end
         end
         B_LD_A: begin
            pos_addr = job_ff.a[AW-1:0];
            state_in = B_LD_B;
         end
         B_LD_B: begin
            pos_addr = job_ff.b[AW-1:0];
            pa_in    = rd_pos;
            state_in = B_LD_C;
         end
         B_LD_C: begin
            pos_addr = job_ff.c[AW-1:0];
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = EDGE_W'(rd_pos[i]) - EDGE_W'(pa_ff[i]);
            end
            state_in = B_LD_D;
         end
         B_LD_D: begin
            for (int i = 0; i < 3; i++) begin
               e2_in[i] = EDGE_W'(rd_pos[i]) - EDGE_W'(pa_ff[i]);
            end
            cnt_in   = 3'd0;
            state_in = B_MUL;
         end
         B_MUL: begin
            if (cnt_ff != 3'd6) begin
               prod_in = mul_a * mul_b;
            end
            if (cnt_ff != 3'd0) begin
               if (!mul_k[0]) begin
                  cr_in[cr_idx] = CR_W'(prod_ff);
               end else begin
                  cr_in[cr_idx] = cr_ff[cr_idx] - CR_W'(prod_ff);
               end
            end
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd6) begin
               state_in = B_MAG;
            end
         end
         B_MAG: begin
            for (int i = 0; i < 3; i++) begin
               mag_in[i] = CMAG_W'(cr_ff[i][CR_W-1] ? -cr_ff[i] : cr_ff[i]);
               neg_in[i] = !cr_ff[i][CR_W-1];
            end
            state_in = B_NORM;
         end
         B_NORM: begin
            if (mag_big) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (mag_zero) begin
               state_in = B_IDLE;
            end else begin
               state_in = B_START;
            end
         end
         B_RD_ACC: begin
            acc_addr = job_ff.a[AW-1:0];
            state_in = B_RD_MAG;
         end
         B_RD_MAG: begin
            for (int i = 0; i < 3; i++) begin
               mag_in[i] = CMAG_W'(acc_wide[i][POS_W] ? -acc_wide[i] : acc_wide[i]);
               neg_in[i] = rd_acc[i][POS_W-1];
            end
            state_in = B_START;
         end
         B_START: begin
            unit_start = 1'b1;
            state_in   = B_WAIT;
         end
         B_WAIT: begin
            if (unit_done) begin
               nvec_in = unit_result;
               if (job_ff.kind == JOB_TRI) begin
                  corner_in = 2'd0;
                  state_in  = unit_result.nonzero ? B_RMW_RD : B_IDLE;
               end else begin
                  state_in = B_OUT;
               end
            end
         end
         B_RMW_RD: begin
            acc_addr = corner_addr;
            state_in = B_RMW_WR;
         end
         B_RMW_WR: begin
            acc_we    = 1'b1;
            acc_addr  = corner_addr;
            acc_wdata = {sat_add(rd_acc[2], nvec_ff.z),
                         sat_add(rd_acc[1], nvec_ff.y),
                         sat_add(rd_acc[0], nvec_ff.x)};
            corner_in = corner_ff + 2'd1;
            state_in  = (corner_ff == 2'd2) ? B_IDLE : B_RMW_RD;
         end
         B_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               out_in       = nvec_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      pa_ff     <= pa_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      prod_ff   <= prod_in;
      cr_ff     <= cr_in;
      cnt_ff    <= cnt_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      corner_ff <= corner_in;
      nvec_ff   <= nvec_in;
      out_ff    <= out_in;
   end

`ifndef SYNTHESIS
   // the clearing pass ends at the last entry
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR && clr_ff == LAST_ADDR) |=> (state_ff == B_IDLE))
      else $error("clearing pass did not end at last entry");

   // a job is only taken from a nonempty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> job_valid)
      else $error("job popped from empty queue");

   // each corner write-back follows the read of that corner
   a_rmw_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RMW_WR) |->
      ($past(state_ff) == B_RMW_RD && $past(corner_ff) == corner_ff))
      else $error("accumulator write without matching read");
`endif

endmodule

`default_nettype wire

>>> sv/vertex_normal_smoothing_core.sv
// vertex normal smoothing core
//
// req channel: one transfer per item. req_tuser carries the action
// (load position, add triangle, read normal). load and triangle items give
// no response; a read gives one rsp transfer with the q1.14 unit normal in
// rsp_tdata and the nonzero flag in rsp_tuser. items with an out-of-range
// index are dropped, except reads, which answer with zeros.
// a front stage classifies items into a two-entry queue; the back sequencer
// works one job at a time. a load writes its position and clears its
// accumulator; a read passes the sum through the shared normalizer; a
// triangle takes three position reads, six products on one multiplier,
// up to 20 normalizing shifts, a 31-step square root and three 15-step
// divisions in the normalizer, then a read-modify-write of each corner
// accumulator. a triangle with parallel edges ends before the normalizer.
// after reset the accumulator store is swept to zero, with req_tready
// low. positions are undefined until loaded.
// a result waits in the output register while rsp_tready is low; the back
// end stalls only when it has a second result ready, and the queue keeps
// taking items until it is full.
`default_nettype none

module vertex_normal_smoothing_core import vns_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
   input  wire logic [111:0] req_tdata,
   // action
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // norm_x, norm_y, norm_z
   output logic [47:0]       rsp_tdata,
   // nonzero
   output logic              rsp_tuser
);

   localparam int OFS_PX = IDX_W;
   localparam int OFS_PY = OFS_PX + POS_W;
   localparam int OFS_PZ = OFS_PY + POS_W;
   localparam int OFS_CA = OFS_PZ + POS_W;
   localparam int OFS_CB = OFS_CA + IDX_W;
   localparam int OFS_CC = OFS_CB + IDX_W;

   back_status_type       status;
   logic                  job_valid;
   job_type               job;
   logic                  unit_start, unit_done;
   logic [2:0][MAG_W-1:0] unit_mag;
   logic [2:0]            unit_neg;
   normal_type            unit_result;
   normal_type            out_data;

   vns_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .action       (action_type'(req_tuser)),
      .vertex_index (req_tdata[IDX_W-1:0]),
      .pos_x        (req_tdata[OFS_PX +: POS_W]),
      .pos_y        (req_tdata[OFS_PY +: POS_W]),
      .pos_z        (req_tdata[OFS_PZ +: POS_W]),
      .corner_a     (req_tdata[OFS_CA +: IDX_W]),
      .corner_b     (req_tdata[OFS_CB +: IDX_W]),
      .corner_c     (req_tdata[OFS_CC +: IDX_W]),
      .status       (status),
      .job_valid    (job_valid),
      .job          (job)
   );

   vns_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start),
      .mag    (unit_mag),
      .neg    (unit_neg),
      .done   (unit_done),
      .result (unit_result)
   );

   vns_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .status      (status),
      .unit_start  (unit_start),
      .unit_mag    (unit_mag),
      .unit_neg    (unit_neg),
      .unit_done   (unit_done),
      .unit_result (unit_result),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (out_data)
   );

   // response packing
   assign rsp_tdata = {out_data.z, out_data.y, out_data.x};
   assign rsp_tuser = out_data.nonzero;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import vns_pkg::*;

   localparam int NVERT = 1024;

   typedef struct {
      action_type        act;
      logic [9:0]        vidx;
      logic signed [23:0] px, py, pz;
      logic [9:0]        ca, cb, cc;
   } tb_item_type;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic               nz;
   } tb_normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [111:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;

   vertex_normal_smoothing_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [23:0] pos_x [NVERT];
   logic signed [23:0] pos_y [NVERT];
   logic signed [23:0] pos_z [NVERT];
   logic signed [23:0] sum_x [NVERT];
   logic signed [23:0] sum_y [NVERT];
   logic signed [23:0] sum_z [NVERT];
   bit loaded [NVERT];

   tb_item_type pending_items[$];
   tb_normal_type expected_normals[$];
   int errors = 0;
   int n_loads = 0, n_tris = 0, n_reads = 0, n_checked = 0;
   bit quiet = 1'b0;
   bit driving_done = 1'b0;

   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // magnitudes plus signs to a rounded q1.14 unit vector
   function automatic tb_normal_type to_unit(input logic [63:0] m0, m1, m2,
                                             input bit s0, s1, s2);
      tb_normal_type r;
      logic [63:0] len, q;
      logic [63:0] m [3];
      bit s [3];
      logic signed [15:0] o [3];
      m[0] = m0; m[1] = m1; m[2] = m2;
      s[0] = s0; s[1] = s1; s[2] = s2;
      len = isqrt(m0 * m0 + m1 * m1 + m2 * m2);
      r = '{0, 0, 0, 1'b0};
      if (len == 0) return r;
      for (int i = 0; i < 3; i++) begin
         q = (m[i] * 64'd16384 + len / 2) / len;
         if (q > 16384) q = 16384;
         o[i] = s[i] ? -$signed(q[15:0]) : $signed(q[15:0]);
      end
      r = '{o[0], o[1], o[2], 1'b1};
      return r;
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [23:0] sat_add(input logic signed [23:0] a,
                                                  input logic signed [15:0] d);
      logic signed [31:0] s;
      s = 32'(a) + 32'(d);
      if (s > 8388607) return 24'sd8388607;
      if (s < -8388608) return -24'sd8388608;
      return s[23:0];
   endfunction

   // apply one accepted item to the vertex model, queue a normal on reads
   task automatic predict_smoothing(input tb_item_type it);
      logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, c0, c1, c2;
      logic [63:0] m0, m1, m2, mx;
      int sh;
      tb_normal_type n;
      int idx [3];
      case (it.act)
         ACT_LOAD: begin
            pos_x[it.vidx] = it.px; pos_y[it.vidx] = it.py; pos_z[it.vidx] = it.pz;
            sum_x[it.vidx] = 0; sum_y[it.vidx] = 0; sum_z[it.vidx] = 0;
         end
         ACT_TRI: begin
            e1x = 64'(pos_x[it.cb]) - 64'(pos_x[it.ca]);
            e1y = 64'(pos_y[it.cb]) - 64'(pos_y[it.ca]);
            e1z = 64'(pos_z[it.cb]) - 64'(pos_z[it.ca]);
            e2x = 64'(pos_x[it.cc]) - 64'(pos_x[it.ca]);
            e2y = 64'(pos_y[it.cc]) - 64'(pos_y[it.ca]);
            e2z = 64'(pos_z[it.cc]) - 64'(pos_z[it.ca]);
            c0 = e1y * e2z - e1z * e2y;
            c1 = e1z * e2x - e1x * e2z;
            c2 = e1x * e2y - e1y * e2x;
            m0 = mag(c0); m1 = mag(c1); m2 = mag(c2);
            mx = m0 > m1 ? m0 : m1;
            if (m2 > mx) mx = m2;
            if (mx != 0) begin
               sh = 0;
               while ((mx >> sh) >= (64'd1 << 30)) sh++;
               n = to_unit(m0 >> sh, m1 >> sh, m2 >> sh, !(c0 < 0), !(c1 < 0), !(c2 < 0));
               if (n.nz) begin
                  idx[0] = it.ca; idx[1] = it.cb; idx[2] = it.cc;
                  for (int i = 0; i < 3; i++) begin
                     sum_x[idx[i]] = sat_add(sum_x[idx[i]], n.x);
                     sum_y[idx[i]] = sat_add(sum_y[idx[i]], n.y);
                     sum_z[idx[i]] = sat_add(sum_z[idx[i]], n.z);
                  end
               end
            end
         end
         ACT_READ: begin
            n = to_unit(mag(64'(sum_x[it.vidx])), mag(64'(sum_y[it.vidx])),
                        mag(64'(sum_z[it.vidx])), sum_x[it.vidx] < 0,
                        sum_y[it.vidx] < 0, sum_z[it.vidx] < 0);
            expected_normals = {expected_normals, n};
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // stimulus builders
   task automatic add_load(input int v, input int x, input int y, input int z);
      tb_item_type it;
      it = '{ACT_LOAD, v[9:0], x[23:0], y[23:0], z[23:0],
             10'($urandom), 10'($urandom), 10'($urandom)};
      loaded[v] = 1'b1;
      pending_items = {pending_items, it};
   endtask

   task automatic add_tri(input int a, input int b, input int c);
      tb_item_type it;
      it = '{ACT_TRI, 10'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
             a[9:0], b[9:0], c[9:0]};
      pending_items = {pending_items, it};
   endtask

   task automatic add_read(input int v);
      tb_item_type it;
      it = '{ACT_READ, v[9:0], 24'($urandom), 24'($urandom), 24'($urandom),
             10'($urandom), 10'($urandom), 10'($urandom)};
      pending_items = {pending_items, it};
   endtask

   task automatic add_none();
      tb_item_type it;
      it = '{ACT_NONE, 10'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
             10'($urandom), 10'($urandom), 10'($urandom)};
      pending_items = {pending_items, it};
   endtask

   function automatic int rand_loaded();
      int v;
      do v = $urandom_range(0, NVERT - 1); while (!loaded[v]);
      return v;
   endfunction

   function automatic int rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 8388607 : -8388608;
         1: return $signed($urandom_range(0, 8191)) - 4096;
         default: return $signed($urandom_range(0, 16777215)) - 8388608;
      endcase
   endfunction

   // driver: one transfer per accepted item, random idle bursts
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_smoothing(pending_items.pop_front());
            case (req_tuser)
               ACT_LOAD: n_loads++;
               ACT_TRI:  n_tris++;
               ACT_READ: n_reads++;
               default: ;
            endcase
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(0, 7);
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               tb_item_type nx;
               nx = pending_items[0];
               req_tvalid <= 1'b1;
               req_tuser <= nx.act;
               req_tdata <= {8'd0, nx.cc, nx.cb, nx.ca, nx.pz, nx.py, nx.px, nx.vidx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response transfer with the oldest expectation
   int stall = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_normals.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               tb_normal_type e;
               e = expected_normals.pop_front();
               n_checked++;
               if ($signed(rsp_tdata[15:0]) != e.x) report("norm_x", $signed(rsp_tdata[15:0]), e.x);
               if ($signed(rsp_tdata[31:16]) != e.y) report("norm_y", $signed(rsp_tdata[31:16]), e.y);
               if ($signed(rsp_tdata[47:32]) != e.z) report("norm_z", $signed(rsp_tdata[47:32]), e.z);
               if (rsp_tuser != e.nz) report("nonzero", rsp_tuser, e.nz);
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall <= $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int v, a, b, c, r;
      for (int i = 0; i < NVERT; i++) begin
         sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
         pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0; loaded[i] = 1'b0;
      end
      // directed: extremes, degenerate and repeated corners, reads of empty sums
      add_read(0);
      add_read(1023);
      add_load(0, 0, 0, 0);
      add_load(1, 4096, 0, 0);
      add_load(2, 0, 4096, 0);
      add_load(1023, 8388607, 8388607, -8388608);
      add_load(1022, -8388608, 8388607, 8388607);
      add_load(1021, 8388607, -8388608, 8388607);
      add_tri(0, 1, 2);
      add_read(0);
      add_tri(1023, 1022, 1021);
      add_read(1023);
      add_tri(0, 0, 1);
      add_tri(0, 1, 1);
      add_read(1);
      add_none();
      add_load(3, 8192, 0, 0);
      add_tri(0, 1, 3);
      add_read(3);
      for (int i = 0; i < 3; i++) add_tri(1023, 1022, 1021);
      add_read(1022);
      add_load(1021, 1, 1, 1);
      add_read(1021);
      // random: mostly well-formed meshes on loaded vertices
      for (int i = 0; i < 730; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25) begin
            v = $urandom_range(0, 3) == 0 ? $urandom_range(0, NVERT - 1)
                                          : $urandom_range(0, 31);
            add_load(v, rand_pos(), rand_pos(), rand_pos());
         end else if (r < 65) begin
            a = rand_loaded(); b = rand_loaded(); c = rand_loaded();
            if ($urandom_range(0, 9) == 0) b = a;
            add_tri(a, b, c);
         end else if (r < 95) begin
            add_read($urandom_range(0, 4) == 0 ? $urandom_range(0, NVERT - 1) : rand_loaded());
         end else begin
            add_none();
         end
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // no idling on either side for the tail of the run
      wait (pending_items.size() < 150);
      quiet = 1'b1;
      wait (pending_items.size() == 0);
      @(posedge clock);
      wait (expected_normals.size() == 0);
      repeat (300) @(posedge clock);
      $display("tb: %0d loads, %0d triangles, %0d reads sent", n_loads, n_tris, n_reads);
      $display("tb: %0d normals compared against the predictor", n_checked);
      if (errors == 0 && expected_normals.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #10000000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
